// File: rtl/grid_pattern_hash_matcher_top_macros.svh
// assertion macros for the grid pattern hash matcher
`ifndef GRID_PATTERN_HASH_MATCHER_TOP_MACROS_SVH
`define GRID_PATTERN_HASH_MATCHER_TOP_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define GPHM_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("gphm assertion failed");

// same check, evaluated during reset as well
`define GPHM_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) else $error("gphm assertion failed");

`endif

// File: rtl/gphm_pkg.sv
// shared types, constants and modular helpers of the grid pattern hash matcher
`default_nettype none
package gphm_pkg;

	localparam logic [31:0] HASH_MOD  = 32'd2147483647;
	localparam logic [30:0] HASH_BASE = 31'd1995433697;
	localparam logic [30:0] HASH_PRM  = 31'd1000000009;
	localparam logic [20:0] COUNT_MAX = 21'h1FFFFF;
	localparam int          QDEPTH    = 4;

	typedef enum logic [1:0] {
		CFG_PAT_ROWS  = 2'd0,
		CFG_PAT_COLS  = 2'd1,
		CFG_GRID_ROWS = 2'd2,
		CFG_GRID_COLS = 2'd3
	} gphm_cfg_idx_t;

	typedef struct packed {
		logic is_grid;
		logic restart_pat;
		logic col_end;
		logic do_col;
		logic do_win;
		logic pat_done;
		logic first_pix;
		logic last_pix;
	} gphm_flags_t;

	typedef struct packed {
		logic [4:0] prow;
		logic [4:0] pcol;
	} gphm_cfg_t;

	typedef enum logic [4:0] {
		BK_IDLE, BK_PMUL1, BK_PMUL1W, BK_PMUL2, BK_PMUL2W, BK_PADD,
		BK_PWGT, BK_PWGTW, BK_PWSET, BK_GWRITE, BK_CMUL, BK_CWAIT,
		BK_CADD, BK_VWRITE, BK_WMUL, BK_WWAIT, BK_WADD, BK_RESULT
	} gphm_bk_state_t;

	function automatic logic [30:0] add_mod(input logic [30:0] a, input logic [30:0] b);
		logic [31:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= HASH_MOD) s = s - HASH_MOD;
		return s[30:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/grid_pattern_hash_matcher_top.sv
// top level of the two-dimensional rolling hash pattern matcher
// pattern characters (tuser 0) build the pattern hash, grid characters (tuser 1) are
// stored in a line buffer of the last MAX_PAT_ROWS rows; each grid pixel from row pattern_rows-1
// on recomputes its column hash (pattern_rows steps) and, when it closes a window, the window
// hash over pattern_cols stored column hashes, all through one shared two-stage multiplier
// modulo 2^31-1. each horner step is a multiply, a wait on the multiplier and an add, and a
// result that waits on the output adds its stall on top. a four-entry queue lets the
// input side run ahead of the hashing side, and the result register lets a new transaction
// start while the previous result waits. no clearing pass after reset is needed.
`default_nettype none
module grid_pattern_hash_matcher_top
	import gphm_pkg::*;
#(
	parameter int MAX_PAT_ROWS  = 16,
	parameter int MAX_PAT_COLS  = 16,
	parameter int MAX_GRID_COLS = 1024,
	parameter int MAX_GRID_ROWS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [6:0] symbol, [7] zero
	input  wire logic [0:0]  s_axis_tuser,   // [0] func
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,   // [0] window_match, [21:1] match_count, [23:22] zero
	output logic             m_axis_tlast    // grid_done
);
	localparam int LINE_W = (MAX_PAT_ROWS > 1) ? $clog2(MAX_PAT_ROWS) : 1;
	localparam int COL_W  = $clog2(MAX_GRID_COLS);
	localparam int QW     = $bits(gphm_flags_t) + 7 + LINE_W + COL_W;

	gphm_cfg_idx_t     cidx;
	gphm_cfg_t         cfg;
	gphm_flags_t       f_flags, b_flags;
	logic [LINE_W-1:0] f_line, b_line;
	logic [COL_W-1:0]  f_col, b_col;
	logic [6:0]        b_sym;
	logic              q_push, q_full, q_pop, q_empty;
	logic [QW-1:0]     q_din, q_dout;
	logic              r_match, r_done;
	logic [20:0]       r_count;

	assign cidx = gphm_cfg_idx_t'(cfg_index);

	// classify and track positions
	gphm_front #(
		.MAX_PAT_ROWS(MAX_PAT_ROWS), .MAX_PAT_COLS(MAX_PAT_COLS),
		.MAX_GRID_COLS(MAX_GRID_COLS), .MAX_GRID_ROWS(MAX_GRID_ROWS),
		.LINE_W(LINE_W), .COL_W(COL_W)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cidx), .cfg_data(cfg_data),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_func(s_axis_tuser[0]),
		.q_full(q_full), .q_push(q_push), .q_flags(f_flags),
		.q_line(f_line), .q_col(f_col), .cfg(cfg)
	);

	// command queue
	assign q_din = {f_flags, s_axis_tdata[6:0], f_line, f_col};

	gphm_fifo #(.W(QW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .din(q_din), .full(q_full),
		.pop(q_pop), .dout(q_dout), .empty(q_empty)
	);

	assign {b_flags, b_sym, b_line, b_col} = q_dout;

	// hashing and result register
	gphm_back #(
		.MAX_PAT_ROWS(MAX_PAT_ROWS), .MAX_GRID_COLS(MAX_GRID_COLS),
		.LINE_W(LINE_W), .COL_W(COL_W)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cidx), .cfg(cfg),
		.q_empty(q_empty), .q_pop(q_pop), .q_flags(b_flags),
		.q_sym(b_sym), .q_line(b_line), .q_col(b_col),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_match(r_match), .out_count(r_count), .out_done(r_done)
	);

	assign m_axis_tdata = {2'b00, r_count, r_match};
	assign m_axis_tlast = r_done;
endmodule
`default_nettype wire

// File: rtl/gphm_fifo.sv
// short command queue between classifier front and hashing back
`default_nettype none
`include "grid_pattern_hash_matcher_top_macros.svh"
module gphm_fifo
	import gphm_pkg::*;
#(
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      dout,
	output logic              empty
);
	localparam int PW = $clog2(QDEPTH);

	logic [W-1:0]  mem_q [QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push && !full) wptr_q <= wptr_q + 1'b1;
			if (pop && !empty) rptr_q <= rptr_q + 1'b1;
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`GPHM_ASSERT(a_no_push_full, clk, arst_n, full |-> !push)
	`GPHM_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= (PW+1)'(QDEPTH))
	`GPHM_ASSERT(a_pop_moves, clk, arst_n, (pop && !empty && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
endmodule
`default_nettype wire

// File: rtl/gphm_front.sv
// front end: config registers, pattern/grid position tracking, item classification
`default_nettype none
module gphm_front
	import gphm_pkg::*;
#(
	parameter int MAX_PAT_ROWS  = 16,
	parameter int MAX_PAT_COLS  = 16,
	parameter int MAX_GRID_COLS = 1024,
	parameter int MAX_GRID_ROWS = 1024,
	parameter int LINE_W        = 4,
	parameter int COL_W         = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire gphm_cfg_idx_t     cfg_index,
	input  wire logic [10:0]       cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_func,
	input  wire logic              q_full,
	output logic                   q_push,
	output gphm_flags_t            q_flags,
	output logic [LINE_W-1:0]      q_line,
	output logic [COL_W-1:0]       q_col,
	output gphm_cfg_t              cfg
);
	logic [4:0]        prow_q, pcol_q;
	logic [10:0]       grows_q, gcols_q;
	logic [9:0]        pos_q;
	logic [4:0]        pcc_q;
	logic [10:0]       row_q;
	logic [COL_W-1:0]  col_q;
	logic [LINE_W-1:0] line_q;

	logic [9:0]  total;
	logic        restart, col_end, do_col, do_win, col_last, row_last;
	logic [4:0]  cur_cc;
	logic [9:0]  cur_pos;
	logic        acc;

	function automatic logic [4:0] clamp5(input logic [4:0] v, input int hi);
		if (v == 5'd0) return 5'd1;
		if (32'(v) > hi) return 5'(hi);
		return v;
	endfunction

	function automatic logic [10:0] clamp11(input logic [10:0] v, input int hi);
		if (v == 11'd0) return 11'd1;
		if (32'(v) > hi) return 11'(hi);
		return v;
	endfunction

	assign acc      = in_valid && in_ready;
	assign in_ready = !q_full;
	assign q_push   = acc;
	assign total    = 10'(prow_q) * 10'(pcol_q);
	assign restart  = (pos_q >= total);
	assign cur_pos  = restart ? 10'd0 : pos_q;
	assign cur_cc   = restart ? 5'd0 : pcc_q;
	assign col_end  = (cur_cc == pcol_q - 5'd1);
	assign do_col   = (row_q >= 11'(prow_q) - 11'd1);
	assign do_win   = do_col && (13'(col_q) >= 13'(pcol_q) - 13'd1);
	assign col_last = (13'(col_q) >= 13'(gcols_q) - 13'd1);
	assign row_last = (row_q >= grows_q - 11'd1);

	always_comb begin
		q_flags             = '0;
		q_flags.is_grid     = in_func;
		q_flags.restart_pat = !in_func && restart;
		q_flags.col_end     = col_end;
		q_flags.do_col      = in_func && do_col;
		q_flags.do_win      = in_func && do_win;
		q_flags.pat_done    = restart;
		q_flags.first_pix   = (row_q == 11'd0) && (col_q == '0);
		q_flags.last_pix    = in_func && col_last && row_last;
	end

	assign q_line   = line_q;
	assign q_col    = col_q;
	assign cfg.prow = prow_q;
	assign cfg.pcol = pcol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prow_q  <= 5'd1;
			pcol_q  <= 5'd1;
			grows_q <= 11'd1;
			gcols_q <= 11'd1;
			pos_q   <= '0;
			pcc_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			line_q  <= '0;
		end else if (cfg_we) begin
			row_q  <= '0;
			col_q  <= '0;
			line_q <= '0;
			unique case (cfg_index)
				CFG_PAT_ROWS: begin
					prow_q <= clamp5(cfg_data[4:0], MAX_PAT_ROWS);
					pos_q  <= '0;
					pcc_q  <= '0;
				end
				CFG_PAT_COLS: begin
					pcol_q <= clamp5(cfg_data[4:0], MAX_PAT_COLS);
					pos_q  <= '0;
					pcc_q  <= '0;
				end
				CFG_GRID_ROWS: grows_q <= clamp11(cfg_data, MAX_GRID_ROWS);
				CFG_GRID_COLS: gcols_q <= clamp11(cfg_data, MAX_GRID_COLS);
				default: ;
			endcase
		end else if (acc) begin
			if (!in_func) begin
				pos_q <= cur_pos + 10'd1;
				pcc_q <= col_end ? 5'd0 : cur_cc + 5'd1;
			end else if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q  <= '0;
					line_q <= '0;
				end else begin
					row_q  <= row_q + 11'd1;
					line_q <= (32'(line_q) == MAX_PAT_ROWS - 1) ? '0 : line_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/gphm_modmul.sv
// two-stage multiplier modulo 2^31-1
`default_nettype none
module gphm_modmul
	import gphm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [30:0] a,
	input  wire logic [30:0] b,
	output logic [30:0]      r_s2
);
	logic [61:0] p_s1;
	logic [31:0] s;

	// fold the high half back in, since 2^31 is 1 modulo the prime
	assign s = {1'b0, p_s1[30:0]} + {1'b0, p_s1[61:31]};

	always_ff @(posedge clk) begin
		p_s1 <= 62'(a) * 62'(b);
		r_s2 <= (s >= HASH_MOD) ? 31'(s - HASH_MOD) : s[30:0];
	end
endmodule
`default_nettype wire

// File: rtl/gphm_back.sv
// back end: pattern hash, line store, column hashes, window hash, result register
`default_nettype none
module gphm_back
	import gphm_pkg::*;
#(
	parameter int MAX_PAT_ROWS  = 16,
	parameter int MAX_GRID_COLS = 1024,
	parameter int LINE_W        = 4,
	parameter int COL_W         = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire gphm_cfg_idx_t     cfg_index,
	input  wire gphm_cfg_t         cfg,
	input  wire logic              q_empty,
	output logic                   q_pop,
	input  wire gphm_flags_t       q_flags,
	input  wire logic [6:0]        q_sym,
	input  wire logic [LINE_W-1:0] q_line,
	input  wire logic [COL_W-1:0]  q_col,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_match,
	output logic [20:0]            out_count,
	output logic                   out_done
);
	localparam int DEPTH  = MAX_PAT_ROWS * MAX_GRID_COLS;
	localparam int ADDR_W = $clog2(DEPTH);

	gphm_bk_state_t state_q, state_d;

	gphm_flags_t       fl_q;
	logic [6:0]        sym_q;
	logic [COL_W-1:0]  col_q, jptr_q;
	logic [LINE_W-1:0] line_q, lptr_q;
	logic [4:0]        step_q;
	logic [30:0]       phash_q, wr_q, wc_q, acc_q;
	logic [20:0]       cnt_q;

	logic [6:0]  st_mem [DEPTH];
	logic [30:0] vm_mem [MAX_GRID_COLS];
	logic [6:0]  st_rdata_q;
	logic [30:0] vm_rdata_q;

	logic [30:0] mul_a, mul_b, mul_r;
	logic        st_we, st_re, vm_we, vm_re, slot_free, match;
	logic [ADDR_W-1:0] st_waddr, st_raddr;
	logic [20:0] cnt_nxt;

	gphm_modmul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .r_s2(mul_r));

	assign slot_free = !out_valid || out_ready;
	assign st_waddr  = ADDR_W'(32'(line_q) * MAX_GRID_COLS + 32'(col_q));
	assign st_raddr  = ADDR_W'(32'(lptr_q) * MAX_GRID_COLS + 32'(col_q));
	assign match     = fl_q.is_grid && fl_q.do_win && fl_q.pat_done && (acc_q == phash_q);
	assign cnt_nxt   = (match && cnt_q != COUNT_MAX) ? cnt_q + 21'd1 : cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:   if (!q_empty) state_d = q_flags.is_grid ? BK_GWRITE : BK_PMUL1;
			BK_PMUL1:  state_d = BK_PMUL1W;
			BK_PMUL1W: state_d = BK_PMUL2;
			BK_PMUL2:  state_d = BK_PMUL2W;
			BK_PMUL2W: state_d = BK_PADD;
			BK_PADD:   state_d = BK_PWGT;
			BK_PWGT:   state_d = BK_PWGTW;
			BK_PWGTW:  state_d = BK_PWSET;
			BK_PWSET:  state_d = BK_RESULT;
			BK_GWRITE: state_d = fl_q.do_col ? BK_CMUL : BK_RESULT;
			BK_CMUL:   state_d = BK_CWAIT;
			BK_CWAIT:  state_d = BK_CADD;
			BK_CADD:   state_d = (step_q == 5'd0) ? BK_VWRITE : BK_CMUL;
			BK_VWRITE: state_d = fl_q.do_win ? BK_WMUL : BK_RESULT;
			BK_WMUL:   state_d = BK_WWAIT;
			BK_WWAIT:  state_d = BK_WADD;
			BK_WADD:   state_d = (step_q == 5'd0) ? BK_RESULT : BK_WMUL;
			BK_RESULT: if (slot_free) state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		st_we = 1'b0;
		st_re = 1'b0;
		vm_we = 1'b0;
		vm_re = 1'b0;
		q_pop = 1'b0;
		unique case (state_q)
			BK_IDLE:   q_pop = !q_empty;
			BK_PMUL1: begin
				mul_a = 31'(sym_q);
				mul_b = wc_q;
			end
			BK_PMUL2: begin
				mul_a = mul_r;
				mul_b = wr_q;
			end
			BK_PWGT: begin
				mul_a = fl_q.col_end ? wr_q : wc_q;
				mul_b = fl_q.col_end ? HASH_BASE : HASH_PRM;
			end
			BK_GWRITE: st_we = 1'b1;
			BK_CMUL: begin
				mul_a = acc_q;
				mul_b = HASH_BASE;
				st_re = 1'b1;
			end
			BK_VWRITE: vm_we = 1'b1;
			BK_WMUL: begin
				mul_a = acc_q;
				mul_b = HASH_PRM;
				vm_re = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_waddr] <= sym_q;
		if (st_re) st_rdata_q <= st_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (vm_we) vm_mem[col_q] <= acc_q;
		if (vm_re) vm_rdata_q <= vm_mem[jptr_q];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				fl_q   <= q_flags;
				sym_q  <= q_sym;
				col_q  <= q_col;
				line_q <= q_line;
				lptr_q <= q_line;
			end
			BK_GWRITE: begin
				acc_q  <= '0;
				step_q <= cfg.prow - 5'd1;
			end
			BK_CADD: begin
				acc_q  <= add_mod(mul_r, 31'(st_rdata_q));
				step_q <= step_q - 5'd1;
				lptr_q <= (lptr_q == '0) ? LINE_W'(MAX_PAT_ROWS - 1) : lptr_q - 1'b1;
			end
			BK_VWRITE: begin
				acc_q  <= '0;
				step_q <= cfg.pcol - 5'd1;
				jptr_q <= col_q;
			end
			BK_WADD: begin
				acc_q  <= add_mod(mul_r, vm_rdata_q);
				step_q <= step_q - 5'd1;
				jptr_q <= jptr_q - 1'b1;
			end
			default: ;
		endcase
		if (state_q == BK_RESULT && slot_free) begin
			out_match <= match;
			out_count <= cnt_nxt;
			out_done  <= fl_q.is_grid && fl_q.last_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			phash_q   <= '0;
			wr_q      <= 31'd1;
			wc_q      <= 31'd1;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cnt_q <= '0;
				if (cfg_index == CFG_PAT_ROWS || cfg_index == CFG_PAT_COLS) begin
					phash_q <= '0;
					wr_q    <= 31'd1;
					wc_q    <= 31'd1;
				end
			end
			if (state_q == BK_IDLE && !q_empty && !q_flags.is_grid && q_flags.restart_pat) begin
				phash_q <= '0;
				wr_q    <= 31'd1;
				wc_q    <= 31'd1;
			end
			if (state_q == BK_PADD) phash_q <= add_mod(phash_q, mul_r);
			if (state_q == BK_PWSET) begin
				if (fl_q.col_end) begin
					wc_q <= 31'd1;
					wr_q <= mul_r;
				end else begin
					wc_q <= mul_r;
				end
			end
			if (state_q == BK_GWRITE && fl_q.first_pix) cnt_q <= '0;
			if (state_q == BK_RESULT && slot_free) begin
				cnt_q     <= cnt_nxt;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
